[rtl/core/md5sh_pkg.sv]
// Package for the streaming MD5 hasher: state and block kind types,
// controller/datapath command and status structs, round tables and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package md5sh_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned WORD_LANES  = 4;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / WORD_LANES;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned WADDR_W     = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W     = 6;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
  localparam logic [1:0]         LAST_WORD  = 2'd3;
  localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
  localparam logic [POS_W-1:0]   POS_NO_LEN = 6'd56;
  localparam logic [7:0]         PAD_BYTE   = 8'h80;
  localparam logic               MODE_BYTE  = 1'b0;
  localparam logic               MODE_FINISH = 1'b1;
  localparam logic [WADDR_W-1:0] LEN_LO_WORD = 4'd14;
  localparam logic [WADDR_W-1:0] LEN_HI_WORD = 4'd15;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_PAD_LEN,
    KIND_LEN
  } kind_t;

  typedef struct packed {
    logic               wr_byte;
    logic               blk_start;
    logic               rd_en;
    logic [ROUND_W-1:0] rd_round;
    logic               round_en;
    logic [ROUND_W-1:0] round;
    logic               fold;
    logic               reinit;
    kind_t              kind;
    logic [1:0]         out_sel;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_hi;
  } status_t;

  function automatic logic [WADDR_W-1:0] md5_g(input logic [ROUND_W-1:0] r);
    logic [WADDR_W-1:0] lo;
    logic [WADDR_W-1:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, s};
    return (v << s) | (v >> rs);
  endfunction

endpackage
`default_nettype wire

[rtl/core/md5_stream_hasher_unit.sv]
// Top level of the streaming MD5 hasher: joins the controller and datapath.
// Depends on md5sh_pkg, md5sh_ctrl, md5sh_dpath and md5sh_ram.
//
// Input channel: each item carries one message byte (tuser mode low) or a
// finish request (tuser mode high, data ignored). Bytes are taken one per
// cycle while the block is idle. When a 64-byte block fills, the block stops
// taking items while it runs a load step, 64 rounds on the single round
// unit, and a fold of the result into the chaining words; bytes of the next
// block are thus not taken until the current block has been folded.
// A finish item runs one padded block, or two when fewer than nine bytes of
// the current block are free, and then offers the four digest words A to D
// on the output channel, one per cycle while the receiver accepts them, the
// last with tlast set. No input item is taken until the receiver has
// accepted all four words; a stalled receiver simply holds the current word
// in place. After the fourth word the chaining words and byte count return
// to their initial values. Reset (rst_n low, synchronous) does the same and
// leaves the block idle with no result pending; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module md5_stream_hasher_unit
  import md5sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [1:0]       out_tuser,  // [1:0] word_index
  output logic             out_tlast
);

  cmd_t    cmd;
  status_t status;

  md5sh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser[0]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .out_index (out_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  md5sh_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .digest_word(out_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/md5sh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/md5sh_dpath.sv]
// Datapath of the MD5 hasher: block buffer RAM lanes, byte counter, padding
// mask, one compression round per cycle and the chaining words.
// Depends on md5sh_pkg and md5sh_ram.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_dpath
  import md5sh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_byte,
  input  wire cmd_t       cmd,
  output status_t         status,
  output logic [31:0]     digest_word
);

  logic [63:0]        count_r;
  logic [63:0]        count_nxt;
  logic [31:0]        chain_r [4];
  logic [31:0]        a_r, b_r, c_r, d_r;
  logic [WADDR_W-1:0] gw_r;
  logic [7:0]         lane_q [WORD_LANES];
  logic [31:0]        msg_word;
  logic [31:0]        round_sum;
  logic [31:0]        b_new;
  logic [63:0]        bit_len;
  logic [POS_W-1:0]   pos;

  assign pos     = count_r[POS_W-1:0];
  assign bit_len = {count_r[60:0], 3'b000};

  assign status.pos_last = (pos == POS_LAST);
  assign status.pos_hi   = (pos >= POS_NO_LEN);

  for (genvar l = 0; l < WORD_LANES; l++) begin : g_lane
    md5sh_ram #(
      .WIDTH(8),
      .DEPTH(BLOCK_WORDS)
    ) u_lane_ram (
      .clk  (clk),
      .we   (cmd.wr_byte && (pos[1:0] == 2'(l))),
      .waddr(pos[POS_W-1:2]),
      .wdata(in_byte),
      .re   (cmd.rd_en),
      .raddr(md5_g(cmd.rd_round)),
      .rdata(lane_q[l])
    );
  end

  always_comb begin
    logic [POS_W-1:0] idx;
    logic             use_data;
    logic             use_len;
    idx      = '0;
    msg_word = '0;
    use_data = (cmd.kind != KIND_LEN);
    use_len  = (cmd.kind == KIND_PAD_LEN) || (cmd.kind == KIND_LEN);
    for (int l = 0; l < WORD_LANES; l++) begin
      idx = {gw_r, 2'(l)};
      if (cmd.kind == KIND_DATA) begin
        msg_word[8*l +: 8] = lane_q[l];
      end else if (use_data && (idx < pos)) begin
        msg_word[8*l +: 8] = lane_q[l];
      end else if (use_data && (idx == pos)) begin
        msg_word[8*l +: 8] = PAD_BYTE;
      end else begin
        msg_word[8*l +: 8] = 8'h00;
      end
    end
    if (use_len && (gw_r == LEN_LO_WORD)) begin
      msg_word = bit_len[31:0];
    end else if (use_len && (gw_r == LEN_HI_WORD)) begin
      msg_word = bit_len[63:32];
    end
  end

  assign round_sum = a_r + md5_f(cmd.round[5:4], b_r, c_r, d_r) + SINE_TAB[cmd.round]
                     + msg_word;
  assign b_new     = b_r + rotl32(round_sum, ROT_TAB[{cmd.round[5:4], cmd.round[1:0]}]);

  always_comb begin
    count_nxt = count_r;
    if (cmd.reinit) begin
      count_nxt = '0;
    end else if (cmd.wr_byte) begin
      count_nxt = count_r + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int k = 0; k < 4; k++) begin
        chain_r[k] <= CHAIN_IV[k];
      end
    end else if (cmd.fold) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      gw_r <= md5_g(cmd.rd_round);
    end
    if (cmd.blk_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.round_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_new;
    end
  end

  assign digest_word = chain_r[cmd.out_sel];

endmodule
`default_nettype wire

[rtl/core/md5sh_ctrl.sv]
// Controller of the MD5 hasher: input and output handshakes, block sequencing
// with padding kinds, round counter and digest word counter.
// Depends on md5sh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_ctrl
  import md5sh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire logic    in_mode,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output logic         out_tlast,
  output logic [1:0]   out_index,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [1:0]         wcnt_r, wcnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && ((in_mode == MODE_FINISH) || status.pos_last)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        unique case (kind_r)
          KIND_DATA: state_nxt = ST_IDLE;
          KIND_PAD:  state_nxt = ST_LOAD;
          default:   state_nxt = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_tready && (wcnt_r == LAST_WORD)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt = kind_r;
    rnd_nxt  = rnd_r;
    wcnt_nxt = wcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_mode == MODE_BYTE) begin
            kind_nxt = KIND_DATA;
          end else begin
            kind_nxt = status.pos_hi ? KIND_PAD : KIND_PAD_LEN;
          end
        end
      end
      ST_LOAD: begin
        rnd_nxt = '0;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
      end
      ST_FOLD: begin
        wcnt_nxt = '0;
        if (kind_r == KIND_PAD) begin
          kind_nxt = KIND_LEN;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          wcnt_nxt = wcnt_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    cmd           = '0;
    cmd.kind      = kind_r;
    cmd.round     = rnd_r;
    cmd.out_sel   = wcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.wr_byte = in_tvalid && (in_mode == MODE_BYTE);
      end
      ST_LOAD: begin
        cmd.blk_start = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_round  = '0;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.rd_en    = (rnd_r != LAST_ROUND);
        cmd.rd_round = rnd_r + 6'd1;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        cmd.reinit = out_tready && (wcnt_r == LAST_WORD);
      end
      default: begin
      end
    endcase
  end

  assign out_index = wcnt_r;
  assign out_tlast = (wcnt_r == LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_DATA;
      rnd_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      rnd_r   <= rnd_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  a_fold_data_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD && kind_r == KIND_DATA) |=> (state_r == ST_IDLE))
    else $error("data block did not return to idle after folding");

  a_load_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND && rnd_r == '0))
    else $error("rounds did not start at round zero");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input accepted while digest words are pending");

  a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == ST_IDLE))
    else $error("controller did not go idle after the last digest word");

  a_pad_then_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD && kind_r == KIND_PAD) |=> (state_r == ST_LOAD && kind_r == KIND_LEN))
    else $error("length block did not follow the padding block");

endmodule
`default_nettype wire
